/* hw/rtl/upd_pkg.sv */
`default_nettype none
package upd_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // up to three decoded bytes for one item, in emit order
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
  } dec_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic dec_t push(input dec_t d, input logic [7:0] x);
    dec_t r;
    r = d;
    case (d.cnt)
      2'd0:    r.b0 = x;
      2'd1:    r.b1 = x;
      default: r.b2 = x;
    endcase
    r.cnt = d.cnt + 2'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/upd_decode.sv */
`default_nettype none
module upd_decode import upd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  input  wire logic       consume,
  output dec_t            dec,
  output phase_t          phase
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [4:0] hv;
  logic [4:0] hh;
  logic       do_plain;

  assign phase = phase_r;

  always_comb begin
    hv        = hex_val(byte_i);
    hh        = hex_val(held_r);
    dec       = '0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    do_plain  = 1'b0;

    unique case (phase_r)
      PH_PCT: begin
        if (hv[4]) begin
          held_nxt  = byte_i;
          phase_nxt = PH_DIGIT;
        end else begin
          dec      = push(dec, CH_PCT);
          do_plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hv[4]) begin
          dec       = push(dec, {hh[3:0], hv[3:0]});
          phase_nxt = PH_IDLE;
        end else begin
          dec      = push(dec, CH_PCT);
          dec      = push(dec, held_r);
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    if (do_plain) begin
      phase_nxt = PH_IDLE;
      if (byte_i == CH_PCT) begin
        phase_nxt = PH_PCT;
      end else if (byte_i == CH_PLUS) begin
        dec = push(dec, CH_SPACE);
      end else begin
        dec = push(dec, byte_i);
      end
    end

    // flush an escape left open at string end
    if (last_i) begin
      if (phase_nxt == PH_PCT || phase_nxt == PH_DIGIT) begin
        dec = push(dec, CH_PCT);
      end
      if (phase_nxt == PH_DIGIT) begin
        dec = push(dec, held_nxt);
      end
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (consume) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/upd_burst.sv */
`default_nettype none
module upd_burst import upd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire dec_t       dec,
  input  wire logic       last_i,
  output logic            can_load,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_last
);

  logic [7:0] b0_r, b1_r, b2_r;
  logic [1:0] cnt_r;
  logic       slast_r;
  logic       take;

  assign out_valid       = (cnt_r != 2'd0);
  assign take            = out_valid && !out_stall;
  assign can_load        = (cnt_r == 2'd0) || (cnt_r == 2'd1 && take);
  assign out_byte        = b0_r;
  assign out_run_last    = (cnt_r == 2'd1);
  assign out_string_last = out_run_last && slast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load && dec.cnt != 2'd0) begin
      cnt_r <= dec.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && dec.cnt != 2'd0) begin
      b0_r    <= dec.b0;
      b1_r    <= dec.b1;
      b2_r    <= dec.b2;
      slast_r <= last_i;
    end else if (take) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/url_percent_decoder_top.sv */
// path: an item is registered at the input, decoded combinationally and loaded into
// the burst register, from which out_byte is driven
// throughput: one item per cycle unless stalled, while each gives at most one byte; the
// output register sends a byte a cycle and stalls input until an item's last byte goes
// reset: synchronous active-low rst_n clears the escape phase and all valid state;
// the held digit is not reset
`default_nettype none
module url_percent_decoder_top import upd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_last
);

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       can_load;
  logic       consume;
  dec_t       dec;
  phase_t     phase;

  assign consume  = in_v_r && can_load;
  assign in_stall = in_v_r && !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  upd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_i  (in_byte_r),
    .last_i  (in_last_r),
    .consume (consume),
    .dec     (dec),
    .phase   (phase)
  );

  upd_burst u_burst (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (consume),
    .dec             (dec),
    .last_i          (in_last_r),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

`ifndef SYNTH
  // a string end always produces at least one byte
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_last_r) |-> (dec.cnt != 2'd0))
    else $error("string end gave no output byte");

  // no escape survives a string end
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_last_r) |=> (phase == PH_IDLE))
    else $error("escape pending after string end");

  a_slast_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_string_last) |-> out_run_last)
    else $error("string_last without run_last");
`endif

endmodule
`default_nettype wire

/* test/tb_url_percent_decoder_top.sv */
`timescale 1ns / 1ps
module tb_url_percent_decoder_top;
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_last;
  } dec_byte_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } raw_item_t;

  // n bytes typed in, packed first byte highest
  typedef struct {
    logic [7:0]  b;
    logic        last;
    bit          typed;
    int          n;
    logic [23:0] bytes;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_last;

  int send_idle_pct = 35;
  int stall_pct = 87;
  int err_count = 0;

  dec_byte_t  decoded_q[$];
  logic [7:0] pred_bytes[$];
  raw_item_t  rand_q[$];

  phase_t     dec_phase = PH_IDLE;
  logic [7:0] held_char = 8'h00;

  dir_row_t dir_rows[25] = '{
    '{"a",   0, 1, 1, {"a", 16'h0}},
    '{"+",   0, 1, 1, {" ", 16'h0}},
    '{8'h00, 0, 1, 1, {8'h00, 16'h0}},
    '{8'hff, 1, 1, 1, {8'hff, 16'h0}},
    '{"%",   0, 1, 0, 24'h0},
    '{"4",   0, 1, 0, 24'h0},
    '{"1",   0, 1, 1, {"A", 16'h0}},
    '{"%",   0, 1, 0, 24'h0},
    '{"f",   0, 1, 0, 24'h0},
    '{"F",   0, 1, 1, {8'hff, 16'h0}},
    '{"%",   0, 1, 0, 24'h0},
    '{"G",   0, 1, 2, {"%", "G", 8'h0}},
    '{"%",   0, 0, 0, 24'h0},
    '{"%",   0, 0, 0, 24'h0},
    '{"9",   0, 0, 0, 24'h0},
    '{"z",   0, 0, 0, 24'h0},
    '{"%",   1, 1, 1, {"%", 16'h0}},
    '{"%",   0, 1, 0, 24'h0},
    '{"a",   1, 1, 2, {"%", "a", 8'h0}},
    '{"%",   0, 0, 0, 24'h0},
    '{"4",   0, 0, 0, 24'h0},
    '{"%",   1, 1, 3, {"%", "4", "%"}},
    '{"%",   0, 0, 0, 24'h0},
    '{"4",   0, 0, 0, 24'h0},
    '{"+",   1, 1, 3, {"%", "4", " "}}
  };

  url_percent_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

  always #2 clk = ~clk;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(int'("0") + v);
    return 8'(($urandom_range(0, 1) ? int'("A") : int'("a")) + v - 10);
  endfunction

  function automatic logic [7:0] rand_nonhex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic decode_plain(input logic [7:0] c);
    if (c == CH_PCT) begin
      dec_phase = PH_PCT;
    end else if (c == CH_PLUS) begin
      pred_bytes.push_back(CH_SPACE);
    end else begin
      pred_bytes.push_back(c);
    end
  endtask

  task automatic predict_decode(input logic [7:0] c, input logic last);
    int hv;
    hv = hex_digit(c);
    pred_bytes.delete();
    case (dec_phase)
      PH_PCT: begin
        if (hv >= 0) begin
          held_char = c;
          dec_phase = PH_DIGIT;
        end else begin
          pred_bytes.push_back(CH_PCT);
          dec_phase = PH_IDLE;
          decode_plain(c);
        end
      end
      PH_DIGIT: begin
        if (hv >= 0) begin
          pred_bytes.push_back(8'(hex_digit(held_char) * 16 + hv));
          dec_phase = PH_IDLE;
        end else begin
          pred_bytes.push_back(CH_PCT);
          pred_bytes.push_back(held_char);
          dec_phase = PH_IDLE;
          decode_plain(c);
        end
      end
      default: begin
        dec_phase = PH_IDLE;
        decode_plain(c);
      end
    endcase
    // escape still open when the string ends goes out literally
    if (last) begin
      if (dec_phase != PH_IDLE) pred_bytes.push_back(CH_PCT);
      if (dec_phase == PH_DIGIT) pred_bytes.push_back(held_char);
      dec_phase = PH_IDLE;
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic last, input bit typed,
                           input int n, input logic [23:0] bytes);
    dec_byte_t e;
    int        k;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_decode(c, last);
    if (typed) begin
      pred_bytes.delete();
      for (k = 0; k < n; k++) pred_bytes.push_back(bytes[23 - 8 * k -: 8]);
    end
    foreach (pred_bytes[j]) begin
      e.data     = pred_bytes[j];
      e.run_last = (j == pred_bytes.size() - 1);
      e.str_last = last && e.run_last;
      decoded_q.push_back(e);
    end
  endtask

  task automatic add_rand(input logic [7:0] c);
    raw_item_t r;
    r.b    = c;
    r.last = ($urandom_range(0, 7) == 0);
    rand_q.push_back(r);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : out_check
    dec_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item, byte %02h", out_byte));
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
        if (out_run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b", out_run_last, want.run_last));
        if (out_string_last !== want.str_last)
          report_mismatch($sformatf("string_last %b, want %b", out_string_last,
                                    want.str_last));
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_url_percent_decoder_top: errors");
    $finish;
  end

  initial begin
    int kind;
    int third;

    // mostly well-formed escapes with random content, some broken ones and noise
    while (rand_q.size() < 185) begin
      kind = $urandom_range(0, 9);
      case (kind) inside
        [0:3]: begin
          add_rand(CH_PCT);
          add_rand(rand_hex_char());
          add_rand(rand_hex_char());
        end
        4: begin
          add_rand(CH_PCT);
          add_rand(rand_nonhex_char());
        end
        5: begin
          add_rand(CH_PCT);
          add_rand(rand_hex_char());
          add_rand(rand_nonhex_char());
        end
        6: add_rand(CH_PLUS);
        default: add_rand(8'($urandom_range(0, 255)));
      endcase
    end
    third = rand_q.size() / 3;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].n,
                dir_rows[i].bytes);

    foreach (rand_q[i]) begin
      if (i == third) begin
        send_idle_pct = 87;
        stall_pct     = 35;
      end else if (i == 2 * third) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      send_item(rand_q[i].b, rand_q[i].last, 1'b0, 0, 24'h0);
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_url_percent_decoder_top: clean");
    end else begin
      $display("tb_url_percent_decoder_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/upd_pkg.sv
hw/rtl/upd_decode.sv
hw/rtl/upd_burst.sv
hw/rtl/url_percent_decoder_top.sv
test/tb_url_percent_decoder_top.sv
